// ===== hdl/sftt_pkg.sv =====
// Shared types and codes for the slotted frame translation table.
`default_nettype none

package sftt_pkg;

    localparam int KIND_W  = 3;
    localparam int CNT_W   = 11;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 3;
    localparam int FRAME_W = 40;

    // transaction kinds
    localparam logic [KIND_W-1:0] OP_REG    = 3'd0;
    localparam logic [KIND_W-1:0] OP_UNREG  = 3'd1;
    localparam logic [KIND_W-1:0] OP_BIND   = 3'd2;
    localparam logic [KIND_W-1:0] OP_GET    = 3'd3;
    localparam logic [KIND_W-1:0] OP_UNBIND = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNMAPPED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BOUND     = 3'd5;
    localparam logic [STAT_W-1:0] ST_NOT_BOUND = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic              capture;
        logic              select;
        logic [KIND_W-1:0] op;
        logic              claim;
        logic              free;
        logic              step;
        logic              pres_we;
        logic              pres_val;
        logic              frame_we;
        logic              respond;
        logic [STAT_W-1:0] code;
        logic              with_idx;
        logic              with_frame;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic too_large;
        logic present;
        logic last_slot;
        logic last_all;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/sftt_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module sftt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/sftt_dp.sv =====
// Datapath: slot registers, slot match, entry address, entry memories, result registers.
`default_nettype none

module sftt_dp #(
    parameter int SLOTS      = 8,
    parameter int SLOT_PAGES = 1024,
    parameter int GFN_BITS   = 40,
    parameter int PFN_BITS   = 40
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [GFN_BITS-1:0]               guest_frame,
    input  wire logic [sftt_pkg::CNT_W-1:0]        page_count,
    input  wire logic [PFN_BITS-1:0]               host_frame,
    input  wire sftt_pkg::cmd_t                    cmd,
    output sftt_pkg::stat_t                        stat,
    output logic                                   done,
    output logic      [sftt_pkg::STAT_W-1:0]       status,
    output logic      [sftt_pkg::FRAME_W-1:0]      frame_out,
    output logic      [sftt_pkg::IDX_W-1:0]        slot_index
);

    localparam int CNT_W       = sftt_pkg::CNT_W;
    localparam int IW          = sftt_pkg::IDX_W;
    localparam int FW          = sftt_pkg::FRAME_W;
    localparam int SW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_DEPTH = SLOTS * SLOT_PAGES;
    localparam int AW          = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int OW          = (SLOT_PAGES > 1) ? $clog2(SLOT_PAGES) : 1;
    localparam int CW          = (GFN_BITS > CNT_W) ? GFN_BITS : CNT_W;

    localparam logic [AW-1:0] PAGES_A     = AW'(SLOT_PAGES);
    localparam logic [AW-1:0] LAST_SLOT_A = AW'(SLOT_PAGES - 1);
    localparam logic [AW-1:0] LAST_ALL_A  = AW'(ENTRY_DEPTH - 1);

    // captured transaction
    logic [GFN_BITS-1:0] gf_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PFN_BITS-1:0] hf_reg;

    // slot table
    logic [SLOTS-1:0]    slot_used_reg;
    logic [GFN_BITS-1:0] slot_start_reg [SLOTS];
    logic [CNT_W-1:0]    slot_len_reg   [SLOTS];

    // registered per-slot compare results
    logic [SLOTS-1:0] free_vec_reg, free_vec_next;
    logic [SLOTS-1:0] eq_vec_reg,   eq_vec_next;
    logic [SLOTS-1:0] cov_vec_reg,  cov_vec_next;
    logic [OW-1:0]    ofs_reg  [SLOTS];
    logic [OW-1:0]    ofs_next [SLOTS];
    logic [GFN_BITS:0] diff    [SLOTS];

    // selection and sweep
    logic [SLOTS-1:0] pick;
    logic             found;
    logic [SW-1:0]    sel_idx;
    logic [AW-1:0]    base;
    logic [AW-1:0]    addr_sel;
    logic [SW-1:0]    sel_slot_reg;
    logic             hit_reg;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    sweep_cnt_reg;

    // entry memories
    logic          pres_we;
    logic          pres_wdata;
    logic          pres_rdata;
    logic [PFN_BITS-1:0] frame_rdata;

    // result registers
    logic                        done_reg;
    logic [sftt_pkg::STAT_W-1:0] status_reg;
    logic [FW-1:0]               frame_reg;
    logic [IW-1:0]               idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gf_reg  <= guest_frame;
            cnt_reg <= page_count;
            hf_reg  <= host_frame;
        end
    end

    // per-slot compares, all slots in parallel
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            diff[s]          = {1'b0, gf_reg} - {1'b0, slot_start_reg[s]};
            free_vec_next[s] = !slot_used_reg[s];
            eq_vec_next[s]   = slot_used_reg[s] && (slot_start_reg[s] == gf_reg);
            cov_vec_next[s]  = slot_used_reg[s] && !diff[s][GFN_BITS] &&
                               (CW'(diff[s][GFN_BITS-1:0]) < CW'(slot_len_reg[s]));
            ofs_next[s]      = OW'(diff[s][GFN_BITS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_vec_reg <= '0;
            eq_vec_reg   <= '0;
            cov_vec_reg  <= '0;
        end
        else
        begin
            free_vec_reg <= free_vec_next;
            eq_vec_reg   <= eq_vec_next;
            cov_vec_reg  <= cov_vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            ofs_reg[s] <= ofs_next[s];
        end
    end

    // lowest-numbered slot of the vector that fits the operation
    always_comb
    begin
        if (cmd.op == sftt_pkg::OP_REG)
        begin
            pick = free_vec_reg;
        end
        else if (cmd.op == sftt_pkg::OP_UNREG)
        begin
            pick = eq_vec_reg;
        end
        else
        begin
            pick = cov_vec_reg;
        end
        found   = 1'b0;
        sel_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (pick[s])
            begin
                found   = 1'b1;
                sel_idx = SW'(s);
            end
        end
        base = AW'(sel_idx) * PAGES_A;
        if (cmd.op == sftt_pkg::OP_REG)
        begin
            addr_sel = base;
        end
        else
        begin
            addr_sel = base + AW'(ofs_reg[sel_idx]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_slot_reg  <= '0;
            hit_reg       <= 1'b0;
            addr_reg      <= '0;
            sweep_cnt_reg <= '0;
            slot_used_reg <= '0;
        end
        else
        begin
            if (cmd.select)
            begin
                sel_slot_reg  <= sel_idx;
                hit_reg       <= found;
                addr_reg      <= addr_sel;
                sweep_cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                addr_reg      <= addr_reg + AW'(1);
                sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
            end
            if (cmd.claim)
            begin
                slot_used_reg[sel_slot_reg] <= 1'b1;
            end
            else if (cmd.free)
            begin
                slot_used_reg[sel_slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
        begin
            slot_start_reg[sel_slot_reg] <= gf_reg;
            slot_len_reg[sel_slot_reg]   <= cnt_reg;
        end
    end

    // sweep steps clear present marks; bind/unbind write them
    assign pres_we    = cmd.step | cmd.pres_we;
    assign pres_wdata = cmd.step ? 1'b0 : cmd.pres_val;

    sftt_ram #(
        .WIDTH (1),
        .DEPTH (ENTRY_DEPTH)
    ) u_pres_ram (
        .clk   (clk),
        .we    (pres_we),
        .addr  (addr_reg),
        .wdata (pres_wdata),
        .rdata (pres_rdata)
    );

    sftt_ram #(
        .WIDTH (PFN_BITS),
        .DEPTH (ENTRY_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (cmd.frame_we),
        .addr  (addr_reg),
        .wdata (hf_reg),
        .rdata (frame_rdata)
    );

    always_comb
    begin
        stat.hit       = hit_reg;
        stat.too_large = 32'(cnt_reg) > 32'(SLOT_PAGES);
        stat.present   = pres_rdata;
        stat.last_slot = (sweep_cnt_reg == LAST_SLOT_A);
        stat.last_all  = (sweep_cnt_reg == LAST_ALL_A);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status_reg <= cmd.code;
            idx_reg    <= cmd.with_idx ? IW'(sel_slot_reg) : '0;
            frame_reg  <= cmd.with_frame ? FW'(frame_rdata) : '0;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign frame_out  = frame_reg;
    assign slot_index = idx_reg;

endmodule

`default_nettype wire

// ===== hdl/sftt_ctrl.sv =====
// Controller state machine: sequences compare, select, decide, entry access and sweeps.
`default_nettype none

module sftt_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [sftt_pkg::KIND_W-1:0]  kind,
    input  wire sftt_pkg::stat_t              stat,
    output logic                              busy,
    output sftt_pkg::cmd_t                    cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [sftt_pkg::KIND_W-1:0]     kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            kind_reg  <= sftt_pkg::OP_REG;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = kind_reg;
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.step = 1'b1;
                if (stat.last_all)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // unknown kinds are taken and dropped without a result
                if (start && (kind <= sftt_pkg::OP_UNBIND))
                begin
                    cmd.capture = 1'b1;
                    kind_next   = kind;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                cmd.select = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_IDLE;
                case (kind_reg)
                    sftt_pkg::OP_REG:
                    begin
                        if (!stat.hit)
                        begin
                            cmd.respond = 1'b1;
                            cmd.code    = sftt_pkg::ST_NO_FREE;
                        end
                        else if (stat.too_large)
                        begin
                            cmd.respond = 1'b1;
                            cmd.code    = sftt_pkg::ST_TOO_LARGE;
                        end
                        else
                        begin
                            cmd.claim  = 1'b1;
                            state_next = S_CLR;
                        end
                    end
                    sftt_pkg::OP_UNREG:
                    begin
                        cmd.respond = 1'b1;
                        if (stat.hit)
                        begin
                            cmd.free     = 1'b1;
                            cmd.code     = sftt_pkg::ST_OK;
                            cmd.with_idx = 1'b1;
                        end
                        else
                        begin
                            cmd.code = sftt_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // entry read is in flight at addr_reg this cycle
                        if (!stat.hit)
                        begin
                            cmd.respond = 1'b1;
                            cmd.code    = sftt_pkg::ST_UNMAPPED;
                        end
                        else
                        begin
                            state_next = S_CHK;
                        end
                    end
                endcase
            end
            S_CLR:
            begin
                cmd.step = 1'b1;
                if (stat.last_slot)
                begin
                    cmd.respond  = 1'b1;
                    cmd.code     = sftt_pkg::ST_OK;
                    cmd.with_idx = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CHK:
            begin
                cmd.respond  = 1'b1;
                cmd.with_idx = 1'b1;
                state_next   = S_IDLE;
                case (kind_reg)
                    sftt_pkg::OP_BIND:
                    begin
                        if (stat.present)
                        begin
                            cmd.code = sftt_pkg::ST_BOUND;
                        end
                        else
                        begin
                            cmd.pres_we  = 1'b1;
                            cmd.pres_val = 1'b1;
                            cmd.frame_we = 1'b1;
                            cmd.code     = sftt_pkg::ST_OK;
                        end
                    end
                    sftt_pkg::OP_GET:
                    begin
                        if (!stat.present)
                        begin
                            cmd.code = sftt_pkg::ST_NOT_BOUND;
                        end
                        else
                        begin
                            cmd.code       = sftt_pkg::ST_OK;
                            cmd.with_frame = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!stat.present)
                        begin
                            cmd.code = sftt_pkg::ST_NOT_BOUND;
                        end
                        else
                        begin
                            cmd.pres_we  = 1'b1;
                            cmd.pres_val = 1'b0;
                            cmd.code     = sftt_pkg::ST_OK;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/slotted_frame_translation_table_unit.sv =====
// Top level of the slotted guest-to-host frame translation table.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  command  | start, busy           | kind, guest_frame, page_count, host_frame
//  result   | done (one-cycle pulse)| status, frame_out, slot_index
//
// A transaction is taken at an edge with start high and busy low. Unregister, a rejected
// register and a lookup miss go through compare, select and decide; bind/get/unbind go
// through compare, select, entry read and entry write; a register that claims
// a slot then clears its present marks one entry a cycle through the single RAM port.
// After reset busy stays high while the present marks of every entry are cleared.
// done pulses in the first cycle busy is low again; the receiver cannot stall it.
`default_nettype none

module slotted_frame_translation_table_unit #(
    parameter int SLOTS      = 8,
    parameter int SLOT_PAGES = 1024,
    parameter int GFN_BITS   = 40,
    parameter int PFN_BITS   = 40
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [sftt_pkg::KIND_W-1:0]       kind,
    input  wire logic [GFN_BITS-1:0]               guest_frame,
    input  wire logic [sftt_pkg::CNT_W-1:0]        page_count,
    input  wire logic [PFN_BITS-1:0]               host_frame,
    output logic                                   done,
    output logic      [sftt_pkg::STAT_W-1:0]       status,
    output logic      [sftt_pkg::FRAME_W-1:0]      frame_out,
    output logic      [sftt_pkg::IDX_W-1:0]        slot_index
);

    sftt_pkg::cmd_t  cmd;
    sftt_pkg::stat_t stat;

    sftt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    sftt_dp #(
        .SLOTS      (SLOTS),
        .SLOT_PAGES (SLOT_PAGES),
        .GFN_BITS   (GFN_BITS),
        .PFN_BITS   (PFN_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .guest_frame (guest_frame),
        .page_count  (page_count),
        .host_frame  (host_frame),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .frame_out   (frame_out),
        .slot_index  (slot_index)
    );

endmodule

`default_nettype wire

// ===== sim/tb_slotted_frame_translation_table_unit.sv =====
// Self-checking testbench for the slotted frame translation table unit.
`timescale 1ns / 100ps

module tb_slotted_frame_translation_table_unit;

    localparam int        KIND_W         = sftt_pkg::KIND_W;
    localparam int        CNT_W          = sftt_pkg::CNT_W;
    localparam int        STAT_W         = sftt_pkg::STAT_W;
    localparam int        IDX_W          = sftt_pkg::IDX_W;
    localparam int        FRAME_W        = sftt_pkg::FRAME_W;
    localparam int        NUM_SLOTS      = 8;
    localparam int        PAGES_PER_SLOT = 1024;
    localparam int        FRAME_BITS     = 40;
    localparam int        ENTRIES        = NUM_SLOTS * PAGES_PER_SLOT;
    localparam int        RAND_OPS       = 1150;
    localparam longint    CYCLE_LIMIT    = 5000000;
    localparam int        KIND_MAX       = (1 << KIND_W) - 1;
    localparam int        KIND_IGNORED   = int'(sftt_pkg::OP_UNBIND) + 1;
    localparam logic [FRAME_W-1:0] TOP_FRAME = '1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   idx;
    } reply_t;

    // Mirror of the slot table and entry memory, plus the replies it owes.
    class frame_table_tracker;
        bit                 in_use [NUM_SLOTS];
        logic [FRAME_W-1:0] base   [NUM_SLOTS];
        logic [CNT_W-1:0]   span   [NUM_SLOTS];
        bit                 mapped [ENTRIES];
        logic [FRAME_W-1:0] target [ENTRIES];
        reply_t             pending_replies [$];
        int                 mismatches;
        int                 compared;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                in_use[i] = 1'b0;
                base[i]   = '0;
                span[i]   = '0;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                mapped[i] = 1'b0;
                target[i] = '0;
            end
            mismatches = 0;
            compared   = 0;
        endfunction

        function int used_count();
            int n;
            n = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (in_use[i])
                    n++;
            return n;
        endfunction

        function int pick_used();
            int ids [$];
            for (int i = 0; i < NUM_SLOTS; i++)
                if (in_use[i])
                    ids.push_back(i);
            if (ids.size() == 0)
                return -1;
            return ids[$urandom_range(ids.size() - 1)];
        endfunction

        function void note_op(logic [KIND_W-1:0] k, logic [FRAME_W-1:0] g,
                              logic [CNT_W-1:0] c, logic [FRAME_W-1:0] h);
            reply_t             r;
            int                 s;
            int                 e;
            logic [FRAME_W-1:0] off;
            r = '0;
            s = -1;
            case (k)
                sftt_pkg::OP_REG: begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (!in_use[i] && s < 0)
                            s = i;
                    if (s < 0)
                        r.status = sftt_pkg::ST_NO_FREE;
                    else if (c > PAGES_PER_SLOT)
                        r.status = sftt_pkg::ST_TOO_LARGE;
                    else begin
                        in_use[s] = 1'b1;
                        base[s]   = g;
                        span[s]   = c;
                        for (int i = 0; i < PAGES_PER_SLOT; i++) begin
                            mapped[s * PAGES_PER_SLOT + i] = 1'b0;
                            target[s * PAGES_PER_SLOT + i] = '0;
                        end
                        r.status = sftt_pkg::ST_OK;
                        r.idx    = IDX_W'(s);
                    end
                end
                sftt_pkg::OP_UNREG: begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (in_use[i] && base[i] == g && s < 0)
                            s = i;
                    if (s < 0)
                        r.status = sftt_pkg::ST_NOT_FOUND;
                    else begin
                        in_use[s] = 1'b0;
                        r.status  = sftt_pkg::ST_OK;
                        r.idx     = IDX_W'(s);
                    end
                end
                sftt_pkg::OP_BIND, sftt_pkg::OP_GET, sftt_pkg::OP_UNBIND: begin
                    // lowest covering slot wins when ranges overlap
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (s < 0 && in_use[i] && g >= base[i] && (g - base[i]) < span[i])
                            s = i;
                    if (s < 0)
                        r.status = sftt_pkg::ST_UNMAPPED;
                    else begin
                        off   = g - base[s];
                        e     = s * PAGES_PER_SLOT + int'(off[CNT_W-1:0]);
                        r.idx = IDX_W'(s);
                        if (k == sftt_pkg::OP_BIND) begin
                            if (mapped[e])
                                r.status = sftt_pkg::ST_BOUND;
                            else begin
                                mapped[e] = 1'b1;
                                target[e] = h;
                                r.status  = sftt_pkg::ST_OK;
                            end
                        end else if (!mapped[e])
                            r.status = sftt_pkg::ST_NOT_BOUND;
                        else if (k == sftt_pkg::OP_GET) begin
                            r.status = sftt_pkg::ST_OK;
                            r.frame  = target[e];
                        end else begin
                            mapped[e] = 1'b0;
                            target[e] = '0;
                            r.status  = sftt_pkg::ST_OK;
                        end
                    end
                end
                default: return;  // unused kinds produce no reply
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] st, logic [FRAME_W-1:0] fr,
                                  logic [IDX_W-1:0] ix);
            reply_t want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected reply st=%0d frame=%h idx=%0d",
                             $realtime, st, fr, ix);
                return;
            end
            want = pending_replies.pop_front();
            compared++;
            if (st !== want.status || fr !== want.frame || ix !== want.idx) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: reply mismatch want st=%0d frame=%h idx=%0d,",
                              " got st=%0d frame=%h idx=%0d"},
                             $realtime, want.status, want.frame, want.idx, st, fr, ix);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     kind;
    logic [FRAME_BITS-1:0] guest_frame;
    logic [CNT_W-1:0]      page_count;
    logic [FRAME_BITS-1:0] host_frame;
    logic                  done;
    logic [STAT_W-1:0]     status;
    logic [FRAME_W-1:0]    frame_out;
    logic [IDX_W-1:0]      slot_index;

    frame_table_tracker sb;
    bit                 idle_ok;
    longint             cycles;
    int                 kind_seen [KIND_MAX + 1];

    slotted_frame_translation_table_unit #(
        .SLOTS      (NUM_SLOTS),
        .SLOT_PAGES (PAGES_PER_SLOT),
        .GFN_BITS   (FRAME_BITS),
        .PFN_BITS   (FRAME_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .guest_frame (guest_frame),
        .page_count  (page_count),
        .host_frame  (host_frame),
        .done        (done),
        .status      (status),
        .frame_out   (frame_out),
        .slot_index  (slot_index)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, sb.pending_replies.size());
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(status, frame_out, slot_index);
    end

    function automatic logic [FRAME_W-1:0] rand40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[FRAME_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue_table_op(input logic [KIND_W-1:0] k, input logic [FRAME_W-1:0] g,
                                  input logic [CNT_W-1:0] c, input logic [FRAME_W-1:0] h);
        int gap;
        if (idle_ok && $urandom_range(99) < 16)
        begin
            gap   = $urandom_range(6, 1);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       = 1'b1;
        kind        = k;
        guest_frame = g;
        page_count  = c;
        host_frame  = h;
        do
            @(posedge clk);
        while (busy);
        sb.note_op(k, g, c, h);
        kind_seen[k]++;
        @(negedge clk);
    endtask

    initial
    begin
        int                 n;
        int                 pick;
        int                 s;
        int                 mode;
        logic [KIND_W-1:0]  k;
        logic [CNT_W-1:0]   c;
        logic [FRAME_W-1:0] g;
        logic [FRAME_W-1:0] h;

        sb          = new();
        cycles      = 0;
        idle_ok     = 1'b1;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = '0;
        guest_frame = '0;
        page_count  = '0;
        host_frame  = '0;
        for (int i = 0; i <= KIND_MAX; i++)
            kind_seen[i] = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, overlap, full table
        issue_table_op(sftt_pkg::OP_GET, '0, '0, '0);
        issue_table_op(sftt_pkg::OP_UNREG, '0, '0, '0);
        for (int i = KIND_IGNORED; i <= KIND_MAX; i++)
            issue_table_op(KIND_W'(i), rand40(), CNT_W'($urandom), rand40());
        issue_table_op(sftt_pkg::OP_REG, TOP_FRAME, 11'd1, '0);
        issue_table_op(sftt_pkg::OP_BIND, TOP_FRAME, '0, TOP_FRAME);
        issue_table_op(sftt_pkg::OP_BIND, TOP_FRAME, '0, '0);
        issue_table_op(sftt_pkg::OP_GET, TOP_FRAME, '0, '0);
        issue_table_op(sftt_pkg::OP_UNBIND, TOP_FRAME, '0, '0);
        issue_table_op(sftt_pkg::OP_GET, TOP_FRAME, '0, '0);
        issue_table_op(sftt_pkg::OP_UNBIND, TOP_FRAME, '0, '0);
        issue_table_op(sftt_pkg::OP_REG, '0, '0, '0);             // slot covering nothing
        issue_table_op(sftt_pkg::OP_GET, '0, '0, '0);
        issue_table_op(sftt_pkg::OP_REG, '0, CNT_W'(PAGES_PER_SLOT + 1), '0);
        issue_table_op(sftt_pkg::OP_REG, '0, CNT_W'(PAGES_PER_SLOT), '0);
        issue_table_op(sftt_pkg::OP_BIND, 40'd1023, '0, '0);
        issue_table_op(sftt_pkg::OP_GET, 40'd1023, '0, '0);
        issue_table_op(sftt_pkg::OP_BIND, 40'd1024, '0, rand40());
        issue_table_op(sftt_pkg::OP_REG, 40'd512, CNT_W'(PAGES_PER_SLOT), '0);
        issue_table_op(sftt_pkg::OP_GET, 40'd600, '0, '0);        // overlap, lower slot wins
        for (int i = 0; i < 4; i++)
            issue_table_op(sftt_pkg::OP_REG, rand40(), CNT_W'($urandom_range(16, 1)), '0);
        issue_table_op(sftt_pkg::OP_REG, '0, '1, '0);             // full beats too large
        issue_table_op(sftt_pkg::OP_UNREG, '0, '0, '0);
        issue_table_op(sftt_pkg::OP_UNREG, '0, '0, '0);

        // random: mostly bind/get/unbind aimed at live slots
        n = 0;
        while (n < RAND_OPS)
        begin
            idle_ok = !(n >= 300 && n < 550);
            pick    = $urandom_range(99);
            c       = CNT_W'($urandom);
            h       = rand40();
            if (pick < 2)
            begin
                issue_table_op(KIND_W'($urandom_range(KIND_MAX, KIND_IGNORED)),
                               rand40(), c, h);
                continue;
            end
            n++;
            if (sb.used_count() < 2 || pick < 10)
            begin
                mode = $urandom_range(9);
                if (mode < 6)
                    c = CNT_W'($urandom_range(32, 1));
                else if (mode == 6)
                    c = '0;
                else if (mode == 7)
                    c = CNT_W'(PAGES_PER_SLOT);
                else if (mode == 8)
                    c = CNT_W'($urandom_range((1 << CNT_W) - 1, PAGES_PER_SLOT + 1));
                else
                    c = CNT_W'($urandom_range(PAGES_PER_SLOT, 33));
                s = sb.pick_used();
                case ($urandom_range(3))
                    0: g = rand40();
                    1: g = TOP_FRAME - FRAME_W'($urandom_range(40));
                    2: g = (s < 0) ? rand40() : sb.base[s] + FRAME_W'($urandom_range(40));
                    default: g = FRAME_W'($urandom_range(4095));
                endcase
                issue_table_op(sftt_pkg::OP_REG, g, c, h);
            end
            else if (pick < 15)
            begin
                s = sb.pick_used();
                g = (s >= 0 && $urandom_range(3) != 0) ? sb.base[s] : rand40();
                issue_table_op(sftt_pkg::OP_UNREG, g, c, h);
            end
            else if (pick < 18)
                issue_table_op(KIND_W'($urandom_range(sftt_pkg::OP_UNBIND, sftt_pkg::OP_BIND)),
                               rand40(), c, h);
            else
            begin
                s = sb.pick_used();
                if (s < 0 || sb.span[s] == 0)
                    g = rand40();
                else if ($urandom_range(19) == 0)
                    g = sb.base[s] + sb.span[s];    // one past the end
                else if ($urandom_range(19) == 0)
                    g = sb.base[s] - 1;
                else
                    g = sb.base[s] + FRAME_W'($urandom_range(sb.span[s] - 1));
                mode = $urandom_range(99);
                k    = (mode < 40) ? sftt_pkg::OP_BIND :
                       (mode < 75) ? sftt_pkg::OP_GET : sftt_pkg::OP_UNBIND;
                if ($urandom_range(19) == 0)
                    h = ($urandom_range(1) != 0) ? TOP_FRAME : '0;
                issue_table_op(k, g, c, h);
            end
        end
        start = 1'b0;

        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d register, %0d unregister, %0d bind, %0d get, %0d unbind ops",
                 kind_seen[sftt_pkg::OP_REG], kind_seen[sftt_pkg::OP_UNREG],
                 kind_seen[sftt_pkg::OP_BIND], kind_seen[sftt_pkg::OP_GET],
                 kind_seen[sftt_pkg::OP_UNBIND]);
        $display("%0d replies compared, %0d mismatches, %0d cycles",
                 sb.compared, sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sftt_pkg.sv
hdl/sftt_ram.sv
hdl/sftt_dp.sv
hdl/sftt_ctrl.sv
hdl/slotted_frame_translation_table_unit.sv
sim/tb_slotted_frame_translation_table_unit.sv
